/* hw/rtl/nar_pkg.sv */
// nar_pkg: shared constants, codes and types of the no-adjacent-repeat rearranger
// no dependencies; used by every other file of the block
`default_nettype none

package nar_pkg;

    localparam int MAX_LEN     = 64;
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int IDX_W       = $clog2(ALPHABET);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NOT_POSSIBLE = 2'd1,
        STATUS_OVERFLOW     = 2'd2
    } status_t;

    // classified input beat handed from front to back
    typedef struct packed {
        logic                in_alpha;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } cmd_t;

    typedef enum logic [2:0] {
        BACK_COLLECT,
        BACK_DECIDE,
        BACK_SCAN,
        BACK_EMIT,
        BACK_STATUS
    } back_state_t;

    typedef struct packed {
        logic collecting;
        logic bursting;
    } back_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/nar_in_if.sv */
// nar_in_if: input channel carrying one letter beat with valid/ready
// depends on nar_pkg for field widths
`default_nettype none

interface nar_in_if;
    logic                          valid;
    logic                          ready;
    logic [nar_pkg::LETTER_W-1:0]  letter;
    logic                          last_in;

    modport source (output valid, output letter, output last_in, input ready);
    modport sink   (input valid, input letter, input last_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nar_out_if.sv */
// nar_out_if: result channel carrying one emitted letter or status beat
// depends on nar_pkg for field widths
`default_nettype none

interface nar_out_if;
    logic                          valid;
    logic                          ready;
    logic [nar_pkg::LETTER_W-1:0]  out_letter;
    logic [nar_pkg::STATUS_W-1:0]  status;
    logic                          last_out;

    modport source (output valid, output out_letter, output status, output last_out,
                     input ready);
    modport sink   (input valid, input out_letter, input status, input last_out,
                     output ready);
endinterface

`default_nettype wire

/* hw/rtl/nar_front.sv */
// nar_front: accepts letter beats, classifies them and queues them for the back end
// depends on nar_pkg and nar_in_if
`default_nettype none

module nar_front (
    input  logic           clk,
    input  logic           rst_n,
    nar_in_if.sink         letters,
    output nar_pkg::cmd_t  q_cmd,
    output logic           q_valid,
    input  logic           q_pop
);

    nar_pkg::cmd_t                 queue_reg [nar_pkg::QUEUE_DEPTH];
    logic [nar_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [nar_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [nar_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [nar_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [nar_pkg::QPTR_W:0]      fill_reg;
    logic [nar_pkg::QPTR_W:0]      fill_next;
    nar_pkg::cmd_t                 cmd_in;
    logic                          push;
    logic                          pop;

    assign letters.ready = (fill_reg != (nar_pkg::QPTR_W+1)'(nar_pkg::QUEUE_DEPTH));
    assign push          = letters.valid && letters.ready;
    assign q_valid       = (fill_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_cmd         = queue_reg[rd_ptr_reg];

    // letter codes beyond the alphabet are carried but not counted
    always_comb
    begin
        cmd_in.in_alpha = ({1'b0, letters.letter} <
                           (nar_pkg::LETTER_W+1)'(nar_pkg::ALPHABET));
        cmd_in.letter   = letters.letter;
        cmd_in.last     = letters.last_in;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (nar_pkg::QPTR_W+1)'(push) - (nar_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/nar_back.sv */
// nar_back: letter histogram, feasibility check and greedy emit burst with output register
// depends on nar_pkg and nar_out_if
`default_nettype none

module nar_back (
    input  logic                clk,
    input  logic                rst_n,
    input  nar_pkg::cmd_t       q_cmd,
    input  logic                q_valid,
    output logic                q_pop,
    nar_out_if.source           results,
    output nar_pkg::back_stat_t stat
);

    nar_pkg::back_state_t          state_reg;
    nar_pkg::back_state_t          state_next;

    logic [nar_pkg::LEN_W-1:0]     counts_reg [nar_pkg::ALPHABET];
    logic [nar_pkg::LEN_W-1:0]     counts_next [nar_pkg::ALPHABET];
    logic [nar_pkg::LEN_W-1:0]     total_reg;
    logic [nar_pkg::LEN_W-1:0]     total_next;
    logic [nar_pkg::LEN_W-1:0]     max_reg;
    logic [nar_pkg::LEN_W-1:0]     max_next;
    logic                          overflow_reg;
    logic                          overflow_next;
    logic [nar_pkg::IDX_W-1:0]     prev_reg;
    logic [nar_pkg::IDX_W-1:0]     prev_next;
    logic                          prev_valid_reg;
    logic                          prev_valid_next;
    logic [nar_pkg::IDX_W-1:0]     scan_idx_reg;
    logic [nar_pkg::IDX_W-1:0]     scan_idx_next;
    logic [nar_pkg::IDX_W-1:0]     best_idx_reg;
    logic [nar_pkg::IDX_W-1:0]     best_idx_next;
    logic [nar_pkg::LEN_W-1:0]     best_cnt_reg;
    logic [nar_pkg::LEN_W-1:0]     best_cnt_next;
    logic [nar_pkg::LEN_W-1:0]     placed_reg;
    logic [nar_pkg::LEN_W-1:0]     placed_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [nar_pkg::LETTER_W-1:0]  out_letter_reg;
    logic [nar_pkg::LETTER_W-1:0]  out_letter_next;
    nar_pkg::status_t              out_status_reg;
    nar_pkg::status_t              out_status_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    logic [nar_pkg::IDX_W-1:0]     rd_idx;
    logic [nar_pkg::LEN_W-1:0]     rd_cnt;
    logic [nar_pkg::LEN_W-1:0]     inc_cnt;
    logic [nar_pkg::LEN_W-1:0]     half_len;
    logic                          out_free;
    logic                          do_count;
    logic                          set_ovf;
    logic                          infeasible;
    logic                          is_final;
    logic                          scan_end;
    logic                          cand;
    logic                          emit_go;
    logic                          status_go;
    logic                          clear_run;

    // shared count read port: letter address while collecting, scan index otherwise
    assign rd_idx   = (state_reg == nar_pkg::BACK_COLLECT) ?
                      q_cmd.letter[nar_pkg::IDX_W-1:0] : scan_idx_reg;
    assign rd_cnt   = ({1'b0, rd_idx} < (nar_pkg::IDX_W+1)'(nar_pkg::ALPHABET)) ?
                      counts_reg[rd_idx] : '0;
    assign inc_cnt  = rd_cnt + 1'b1;
    assign half_len = nar_pkg::LEN_W'(({1'b0, total_reg} + 1'b1) >> 1);

    assign out_free   = !out_valid_reg || results.ready;
    assign infeasible = (max_reg > half_len);
    assign is_final   = (placed_reg == total_reg - 1'b1);
    assign scan_end   = (scan_idx_reg == nar_pkg::IDX_W'(nar_pkg::ALPHABET - 1));
    assign cand       = (rd_cnt > best_cnt_reg) &&
                        !(prev_valid_reg && (prev_reg == scan_idx_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nar_pkg::BACK_COLLECT:
            begin
                if (q_valid && q_cmd.last)
                begin
                    state_next = nar_pkg::BACK_DECIDE;
                end
            end
            nar_pkg::BACK_DECIDE:
            begin
                if (overflow_reg)
                begin
                    state_next = nar_pkg::BACK_STATUS;
                end
                else if (total_reg == '0)
                begin
                    state_next = nar_pkg::BACK_COLLECT;
                end
                else if (infeasible)
                begin
                    state_next = nar_pkg::BACK_STATUS;
                end
                else
                begin
                    state_next = nar_pkg::BACK_SCAN;
                end
            end
            nar_pkg::BACK_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = nar_pkg::BACK_EMIT;
                end
            end
            nar_pkg::BACK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_final ? nar_pkg::BACK_COLLECT : nar_pkg::BACK_SCAN;
                end
            end
            nar_pkg::BACK_STATUS:
            begin
                if (out_free)
                begin
                    state_next = nar_pkg::BACK_COLLECT;
                end
            end
            default:
            begin
                state_next = nar_pkg::BACK_COLLECT;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = (state_reg == nar_pkg::BACK_COLLECT) && q_valid;
        do_count  = q_pop && q_cmd.in_alpha &&
                    (total_reg < nar_pkg::LEN_W'(nar_pkg::MAX_LEN));
        set_ovf   = q_pop && q_cmd.in_alpha &&
                    (total_reg == nar_pkg::LEN_W'(nar_pkg::MAX_LEN));
        emit_go   = (state_reg == nar_pkg::BACK_EMIT) && out_free;
        status_go = (state_reg == nar_pkg::BACK_STATUS) && out_free;
        clear_run = ((state_reg == nar_pkg::BACK_DECIDE) && !overflow_reg &&
                     (total_reg == '0)) ||
                    (emit_go && is_final) || status_go;
        stat.collecting = (state_reg == nar_pkg::BACK_COLLECT);
        stat.bursting   = (state_reg == nar_pkg::BACK_SCAN) ||
                          (state_reg == nar_pkg::BACK_EMIT);
    end

    // datapath next values
    always_comb
    begin
        counts_next     = counts_reg;
        total_next      = total_reg;
        max_next        = max_reg;
        overflow_next   = overflow_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        placed_next     = placed_reg;

        if (do_count)
        begin
            counts_next[q_cmd.letter[nar_pkg::IDX_W-1:0]] = inc_cnt;
            total_next = total_reg + 1'b1;
            if (inc_cnt > max_reg)
            begin
                max_next = inc_cnt;
            end
        end
        if (set_ovf)
        begin
            overflow_next = 1'b1;
        end

        if (state_reg == nar_pkg::BACK_DECIDE)
        begin
            scan_idx_next = '0;
            best_cnt_next = '0;
            placed_next   = '0;
        end

        if (state_reg == nar_pkg::BACK_SCAN)
        begin
            if (cand)
            begin
                best_idx_next = scan_idx_reg;
                best_cnt_next = rd_cnt;
            end
            scan_idx_next = scan_end ? '0 : scan_idx_reg + 1'b1;
        end

        if (emit_go)
        begin
            counts_next[best_idx_reg] = counts_reg[best_idx_reg] - 1'b1;
            prev_next       = best_idx_reg;
            prev_valid_next = 1'b1;
            placed_next     = placed_reg + 1'b1;
            best_cnt_next   = '0;
        end

        if (clear_run)
        begin
            for (int i = 0; i < nar_pkg::ALPHABET; i++)
            begin
                counts_next[i] = '0;
            end
            total_next      = '0;
            max_next        = '0;
            overflow_next   = 1'b0;
            prev_next       = '0;
            prev_valid_next = 1'b0;
            scan_idx_next   = '0;
            best_cnt_next   = '0;
            placed_next     = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !results.ready;
        out_letter_next = out_letter_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit_go)
        begin
            out_valid_next  = 1'b1;
            out_letter_next = nar_pkg::LETTER_W'(best_idx_reg);
            out_status_next = nar_pkg::STATUS_OK;
            out_last_next   = is_final;
        end
        else if (status_go)
        begin
            out_valid_next  = 1'b1;
            out_letter_next = '0;
            out_status_next = overflow_reg ? nar_pkg::STATUS_OVERFLOW :
                                             nar_pkg::STATUS_NOT_POSSIBLE;
            out_last_next   = 1'b1;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_letter = out_letter_reg;
    assign results.status     = out_status_reg;
    assign results.last_out   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nar_pkg::BACK_COLLECT;
            for (int i = 0; i < nar_pkg::ALPHABET; i++)
            begin
                counts_reg[i] <= '0;
            end
            total_reg      <= '0;
            max_reg        <= '0;
            overflow_reg   <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            scan_idx_reg   <= '0;
            best_cnt_reg   <= '0;
            placed_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            counts_reg     <= counts_next;
            total_reg      <= total_next;
            max_reg        <= max_next;
            overflow_reg   <= overflow_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            scan_idx_reg   <= scan_idx_next;
            best_cnt_reg   <= best_cnt_next;
            placed_reg     <= placed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        out_letter_reg <= out_letter_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/no_adjacent_repeat_rearranger.sv */
// no_adjacent_repeat_rearranger: top level joining the classifying front end and the emit back end
// depends on nar_pkg, nar_in_if, nar_out_if, nar_front, nar_back
//
//   channel   modport   beat fields                     meaning
//   letters   sink      letter[4:0], last_in            one letter of the string
//   results   source    out_letter[4:0], status[1:0],   one rearranged letter or one status
//                       last_out
//
// letters enter one per cycle into a two-beat queue while it has room; the back end counts
// one per cycle while collecting; at run end a decide state, then for each emitted letter a
// scan of the 26 count registers through one read port and an emit step that waits for a
// free output register; a status result takes the decide and the status state, an empty run
// only the decide state; reset clears all counts at once; a stalled result holds the back end
// but the queue keeps taking letters until full
`default_nettype none

module no_adjacent_repeat_rearranger (
    input  logic      clk,
    input  logic      rst_n,
    nar_in_if.sink    letters,
    nar_out_if.source results
);

    nar_pkg::cmd_t       q_cmd;
    logic                q_valid;
    logic                q_pop;
    nar_pkg::back_stat_t stat;

    nar_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .letters (letters),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    nar_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .results (results),
        .stat    (stat)
    );

    // queue drains only while the back end is collecting
    a_pop_when_collecting: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> (stat.collecting && q_valid)
    ) else $error("queue popped outside collect");

    // a full queue always presents a beat to the back end
    a_full_has_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        !letters.ready |-> q_valid
    ) else $error("queue full but empty at output");

    // a status beat is the only beat of its run and carries letter zero
    a_status_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        (results.valid && (results.status != nar_pkg::STATUS_OK)) |->
            (results.last_out && (results.out_letter == '0))
    ) else $error("malformed status beat");

    // no letter is taken from the queue during a burst
    a_burst_holds_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.bursting |-> !q_pop
    ) else $error("queue popped during burst");

endmodule

`default_nettype wire

/* tb/sv/nar_arrangement_checker.sv */
// nar_arrangement_checker: watches the letter and result channels, predicts each run's
// rearranged output and compares every result beat with the oldest prediction
// depends on nar_pkg, nar_in_if, nar_out_if
`default_nettype none

module nar_arrangement_checker (
    input  logic clk,
    input  logic rst_n,
    nar_in_if    letters,
    nar_out_if   results,
    output int   mismatches,
    output int   pending,
    output int   runs_closed,
    output int   beats_checked
);

    typedef struct packed {
        logic [nar_pkg::LETTER_W-1:0] letter;
        nar_pkg::status_t             status;
        logic                         last;
    } result_beat_t;

    logic [nar_pkg::LEN_W-1:0] tally [nar_pkg::ALPHABET];
    logic [nar_pkg::LEN_W-1:0] run_len = '0;
    logic                      overflowed = 1'b0;
    result_beat_t              arranged_q [$];
    result_beat_t              want;
    int                        mismatch_cnt = 0;
    int                        run_cnt = 0;
    int                        beat_cnt = 0;

    initial
    begin
        foreach (tally[i])
            tally[i] = '0;
    end

    // greedy: largest remaining count unlike the previous letter, ties to the lowest code
    task automatic close_run();
        logic [nar_pkg::LEN_W-1:0]    left [nar_pkg::ALPHABET];
        logic [nar_pkg::LETTER_W-1:0] order [$];
        logic [nar_pkg::LETTER_W-1:0] prev;
        logic                         prev_ok;
        int                           best;
        result_beat_t                 beat;
        left = tally;
        prev = '0;
        prev_ok = 1'b0;
        while (order.size() < run_len)
        begin
            best = -1;
            for (int i = 0; i < nar_pkg::ALPHABET; i++)
            begin
                if (left[i] != 0 && !(prev_ok && prev == i) &&
                    (best < 0 || left[i] > left[best]))
                    best = i;
            end
            if (best < 0)
                break;
            left[best] = left[best] - 1'b1;
            prev = nar_pkg::LETTER_W'(best);
            prev_ok = 1'b1;
            order = {order, prev};
        end
        if (overflowed)
        begin
            beat = '{letter: '0, status: nar_pkg::STATUS_OVERFLOW, last: 1'b1};
            arranged_q = {arranged_q, beat};
        end
        else if (run_len != 0)
        begin
            if (order.size() != run_len)
            begin
                beat = '{letter: '0, status: nar_pkg::STATUS_NOT_POSSIBLE, last: 1'b1};
                arranged_q = {arranged_q, beat};
            end
            else
            begin
                foreach (order[k])
                begin
                    beat = '{letter: order[k], status: nar_pkg::STATUS_OK,
                             last: (k == order.size() - 1)};
                    arranged_q = {arranged_q, beat};
                end
            end
        end
        foreach (tally[i])
            tally[i] = '0;
        run_len = '0;
        overflowed = 1'b0;
        run_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                beat_cnt++;
                if (arranged_q.size() == 0)
                begin
                    $display("%0t: unexpected result, got letter %0d status %0d last %0d",
                             $time, results.out_letter, results.status, results.last_out);
                    mismatch_cnt++;
                end
                else
                begin
                    want = arranged_q.pop_front();
                    if (results.out_letter !== want.letter ||
                        results.status !== want.status ||
                        results.last_out !== want.last)
                    begin
                        $display("%0t: result mismatch, expected letter %0d status %0d last %0d",
                                 $time, want.letter, want.status, want.last);
                        $display("%0t:                  got letter %0d status %0d last %0d",
                                 $time, results.out_letter, results.status, results.last_out);
                        mismatch_cnt++;
                    end
                end
            end
            if (letters.valid && letters.ready)
            begin
                if (letters.letter < nar_pkg::ALPHABET)
                begin
                    if (run_len < nar_pkg::MAX_LEN)
                    begin
                        tally[letters.letter] = tally[letters.letter] + 1'b1;
                        run_len = run_len + 1'b1;
                    end
                    else
                        overflowed = 1'b1;
                end
                if (letters.last_in)
                    close_run();
            end
        end
        mismatches    <= mismatch_cnt;
        pending       <= arranged_q.size();
        runs_closed   <= run_cnt;
        beats_checked <= beat_cnt;
    end

endmodule

`default_nettype wire

/* tb/sv/no_adjacent_repeat_rearranger_test.sv */
// no_adjacent_repeat_rearranger_test: drives letter runs with random pacing, paces the
// result channel and gives the verdict from nar_arrangement_checker
// depends on nar_pkg, nar_in_if, nar_out_if, nar_arrangement_checker and the block
`default_nettype none

module no_adjacent_repeat_rearranger_test;

    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int LETTER_TARGET = 250;
    localparam int CODE_MAX      = (1 << nar_pkg::LETTER_W) - 1;

    typedef enum {RUN_SHORT, RUN_FULL, RUN_OVER} run_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   letters_sent = 0;
    int   idle_cycles = 0;
    int   sink_hold = 0;
    int   mismatches;
    int   pending;
    int   runs_closed;
    int   beats_checked;

    nar_in_if  letters();
    nar_out_if results();

    no_adjacent_repeat_rearranger i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .letters (letters),
        .results (results)
    );

    nar_arrangement_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .letters       (letters),
        .results       (results),
        .mismatches    (mismatches),
        .pending       (pending),
        .runs_closed   (runs_closed),
        .beats_checked (beats_checked)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_letter(input logic [nar_pkg::LETTER_W-1:0] code, input logic is_last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            letters.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        letters.valid   <= 1'b1;
        letters.letter  <= code;
        letters.last_in <= is_last;
        do @(posedge clk); while (!letters.ready);
        if (code < nar_pkg::ALPHABET)
            letters_sent++;
    endtask

    task automatic random_run(input run_kind_t kind);
        int                           len;
        int                           span;
        int                           base;
        logic [nar_pkg::LETTER_W-1:0] heavy;
        logic                         heavy_on;
        logic                         end_on_noise;
        logic [nar_pkg::LETTER_W-1:0] code;
        case (kind)
            RUN_FULL: len = nar_pkg::MAX_LEN;
            RUN_OVER: len = $urandom_range(nar_pkg::MAX_LEN + 1, nar_pkg::MAX_LEN + 4);
            default:  len = $urandom_range(1, 12);
        endcase
        if (kind == RUN_SHORT)
            span = $urandom_range(1, nar_pkg::ALPHABET);
        else
            span = $urandom_range(nar_pkg::ALPHABET / 2, nar_pkg::ALPHABET);
        base = $urandom_range(0, nar_pkg::ALPHABET - span);
        heavy = nar_pkg::LETTER_W'(base + $urandom_range(0, span - 1));
        heavy_on = (kind == RUN_SHORT) && ($urandom_range(0, 2) == 0);
        end_on_noise = ($urandom_range(0, 14) == 0);
        calm <= ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_letter(nar_pkg::LETTER_W'($urandom_range(nar_pkg::ALPHABET, CODE_MAX)),
                            1'b0);
            if (heavy_on && $urandom_range(0, 1) == 0)
                code = heavy;
            else
                code = nar_pkg::LETTER_W'(base + $urandom_range(0, span - 1));
            send_letter(code, (k == len - 1) && !end_on_noise);
        end
        if (end_on_noise)
            send_letter(nar_pkg::LETTER_W'($urandom_range(nar_pkg::ALPHABET, CODE_MAX)), 1'b1);
    endtask

    always @(posedge clk)
    begin : sink_pace
        int gap;
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (sink_hold > 0)
            begin
                results.ready <= 1'b0;
                sink_hold <= sink_hold - 1;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0 && $urandom_range(0, 2) == 0)
                begin
                    results.ready <= 1'b0;
                    sink_hold <= gap - 1;
                end
                else
                    results.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (letters.valid && letters.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("no_adjacent_repeat_rearranger_test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int full_at;
        int over_at;
        int run_no;
        rst_n           <= 1'b0;
        letters.valid   <= 1'b0;
        letters.letter  <= '0;
        letters.last_in <= 1'b0;
        calm            <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single letters at both ends of the alphabet
        send_letter(5'd0, 1'b1);
        send_letter(5'd25, 1'b1);
        // empty run ended by an out-of-alphabet code
        send_letter(5'd31, 1'b1);
        // tie goes to the lowest code
        send_letter(5'd1, 1'b0);
        send_letter(5'd0, 1'b1);
        // largest count exactly at the limit
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b1);
        // one over the limit
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b1);
        // ignored code inside an impossible run
        send_letter(5'd0, 1'b0);
        send_letter(5'd26, 1'b0);
        send_letter(5'd0, 1'b1);
        // alternating pair with equal counts
        send_letter(5'd2, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd1, 1'b1);
        // run ends on an ignored code
        send_letter(5'd3, 1'b0);
        send_letter(5'd30, 1'b1);

        full_at = $urandom_range(1, 5);
        over_at = full_at + $urandom_range(1, 5);
        run_no = 0;
        while (letters_sent < LETTER_TARGET)
        begin
            if (run_no == full_at)
                random_run(RUN_FULL);
            else if (run_no == over_at)
                random_run(RUN_OVER);
            else
                random_run(RUN_SHORT);
            run_no++;
        end
        letters.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d letters in %0d runs, checked %0d result beats",
                 letters_sent, runs_closed, beats_checked);
        $display("runs: ties, impossible, empty, ignored codes, full length and overflow");
        if (mismatches == 0 && pending == 0)
            $display("no_adjacent_repeat_rearranger_test passed");
        else
            $display("no_adjacent_repeat_rearranger_test failed");
        $finish;
    end

endmodule

`default_nettype wire
